>>> rtl/sae_pkg.sv
// Shared types and constants for the SPI absolute encoder reader.
// Holds op codes, phases, command bytes and the item structs.
// No dependencies.
package sae_pkg;

  localparam int NUM_ENCODERS = 3;
  localparam int ENC_IDX_W    = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

  localparam int OP_W      = 2;
  localparam int CH_W      = 2;
  localparam int BYTE_W    = 8;
  localparam int NIB_W     = 4;
  localparam int RAW_W     = 12;
  localparam int TRY_W     = 7;
  localparam int TURN_W    = 20;
  localparam int POS_W     = TURN_W + RAW_W;
  localparam int STEP_W    = RAW_W + 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TRY_W;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [BYTE_W-1:0] CMD_READ = 8'h10;
  localparam logic [BYTE_W-1:0] CMD_POLL = 8'h00;
  localparam logic [BYTE_W-1:0] CMD_ZERO = 8'h70;
  localparam logic [BYTE_W-1:0] ACK_ZERO = 8'h80;

  localparam logic [TRY_W-1:0] READ_LIMIT_RST = 7'd80;
  localparam logic [TRY_W-1:0] ZERO_LIMIT_RST = 7'd120;

  localparam logic signed [STEP_W-1:0] HALF_TURN     = 13'sd2048;
  localparam logic signed [STEP_W-1:0] NEG_HALF_TURN = -13'sd2048;
  localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
  localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_ZERO  = 2'd1,
    OP_REPLY = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_RD_CMD  = 3'd1,
    PH_RD_POLL = 3'd2,
    PH_RD_MSB  = 3'd3,
    PH_RD_LSB  = 3'd4,
    PH_ZR_CMD  = 3'd5,
    PH_ZR_POLL = 3'd6
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_READ_LIMIT = 1'd0,
    REG_ZERO_LIMIT = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    op_t               op;
    logic [CH_W-1:0]   channel;
    logic              ch_ok;
    logic [BYTE_W-1:0] rx_byte;
  } cmd_t;

  typedef struct packed {
    logic                    send_valid;
    logic [BYTE_W-1:0]       send_byte;
    logic [CH_W-1:0]         send_channel;
    logic                    done_res;
    logic                    done_kind;
    logic                    status;
    logic [RAW_W-1:0]        raw_count;
    logic signed [POS_W-1:0] position;
  } result_t;

endpackage

>>> rtl/sae_if.sv
// Valid/ready channel interfaces for the encoder reader items.
// Depends on sae_pkg for field widths.
interface sae_in_if import sae_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CH_W-1:0]   channel;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, op, channel, rx_byte, input ready);
  modport sink   (input valid, op, channel, rx_byte, output ready);
endinterface

interface sae_out_if import sae_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    send_valid;
  logic [BYTE_W-1:0]       send_byte;
  logic [CH_W-1:0]         send_channel;
  logic                    done_res;
  logic                    done_kind;
  logic                    status;
  logic [RAW_W-1:0]        raw_count;
  logic signed [POS_W-1:0] position;

  modport source (output valid, send_valid, send_byte, send_channel, done_res, done_kind,
                  status, raw_count, position, input ready);
  modport sink   (input valid, send_valid, send_byte, send_channel, done_res, done_kind,
                  status, raw_count, position, output ready);
endinterface

>>> rtl/sae_front.sv
// Input side: accepts items, classifies the channel and queues them.
// Depends on sae_pkg and sae_in_if.
module sae_front import sae_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  sae_in_if.sink       in_item,
  output cmd_t         cmd,
  output logic         cmd_valid,
  input  logic         cmd_ready
);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push, pop;
  cmd_t              cmd_in;

  assign in_item.ready = (cnt_r != QCNT_W'(QDEPTH));
  assign push = in_item.valid && in_item.ready;
  assign cmd_valid = (cnt_r != '0);
  assign pop  = cmd_valid && cmd_ready;
  assign cmd  = q_r[rd_ptr_r];

  always_comb begin
    cmd_in.op      = op_t'(in_item.op);
    cmd_in.channel = in_item.channel;
    cmd_in.ch_ok   = (32'(in_item.channel) < NUM_ENCODERS);
    cmd_in.rx_byte = in_item.rx_byte;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> rtl/sae_back.sv
// Execution side: transaction sequencer, turn tracking and result register.
// Depends on sae_pkg and sae_out_if.
module sae_back import sae_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  cmd_t                  cmd,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  sae_out_if.source             out_item
);

  phase_t                   phase_r, phase_nxt;
  logic [CH_W-1:0]          act_ch_r, act_ch_nxt;
  logic                     act_kind_r, act_kind_nxt;
  logic [TRY_W-1:0]         try_r, try_nxt;
  logic [NIB_W-1:0]         nib_r, nib_nxt;
  logic [TRY_W-1:0]         rd_lim_r, zr_lim_r;
  logic [RAW_W-1:0]         last_raw_r [NUM_ENCODERS];
  logic signed [TURN_W-1:0] turn_r     [NUM_ENCODERS];
  logic                     out_valid_r;
  result_t                  out_res_r, res_nxt;

  logic                     take;
  logic [TRY_W-1:0]         try_inc;
  logic                     rd_timeout, zr_timeout;
  logic [RAW_W-1:0]         raw;
  logic [RAW_W-1:0]         cur_raw;
  logic signed [TURN_W-1:0] cur_turn, turn_new;
  logic signed [STEP_W-1:0] step;
  logic                     trk_we;
  logic [CH_W-1:0]          trk_ch;
  logic [RAW_W-1:0]         trk_raw;
  logic signed [TURN_W-1:0] trk_turn;

  assign cmd_ready = !out_valid_r || out_item.ready;
  assign take      = cmd_valid && cmd_ready;

  assign try_inc    = try_r + 1'b1;
  assign rd_timeout = (try_inc >= rd_lim_r);
  assign zr_timeout = (try_inc >= zr_lim_r);

  assign raw      = {nib_r, cmd.rx_byte};
  assign cur_raw  = last_raw_r[act_ch_r[ENC_IDX_W-1:0]];
  assign cur_turn = turn_r[act_ch_r[ENC_IDX_W-1:0]];
  assign step     = signed'({1'b0, raw}) - signed'({1'b0, cur_raw});

  always_comb begin
    turn_new = cur_turn;
    if (step > HALF_TURN) begin
      if (cur_turn != TURN_MIN) turn_new = cur_turn - 1'b1;
    end else if (step < NEG_HALF_TURN) begin
      if (cur_turn != TURN_MAX) turn_new = cur_turn + 1'b1;
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      case (cmd.op)
        OP_READ: begin
          if (phase_r == PH_IDLE && cmd.ch_ok) phase_nxt = PH_RD_CMD;
        end
        OP_ZERO: begin
          if (phase_r == PH_IDLE && cmd.ch_ok) phase_nxt = PH_ZR_CMD;
        end
        OP_REPLY: begin
          case (phase_r)
            PH_RD_CMD:  phase_nxt = PH_RD_POLL;
            PH_RD_POLL: begin
              if (cmd.rx_byte == CMD_READ) phase_nxt = PH_RD_MSB;
              else if (rd_timeout)         phase_nxt = PH_IDLE;
            end
            PH_RD_MSB:  phase_nxt = PH_RD_LSB;
            PH_RD_LSB:  phase_nxt = PH_IDLE;
            PH_ZR_CMD:  phase_nxt = PH_ZR_POLL;
            PH_ZR_POLL: begin
              if (cmd.rx_byte == ACK_ZERO || zr_timeout) phase_nxt = PH_IDLE;
            end
            default:    phase_nxt = PH_IDLE;
          endcase
        end
        default: ;
      endcase
    end
  end

  // results and datapath updates
  always_comb begin
    res_nxt      = '0;
    act_ch_nxt   = act_ch_r;
    act_kind_nxt = act_kind_r;
    try_nxt      = try_r;
    nib_nxt      = nib_r;
    trk_we       = 1'b0;
    trk_ch       = act_ch_r;
    trk_raw      = raw;
    trk_turn     = turn_new;
    case (cmd.op)
      OP_READ, OP_ZERO: begin
        if (phase_r == PH_IDLE && cmd.ch_ok) begin
          act_ch_nxt           = cmd.channel;
          act_kind_nxt         = (cmd.op == OP_ZERO);
          try_nxt              = '0;
          res_nxt.send_valid   = 1'b1;
          res_nxt.send_byte    = (cmd.op == OP_READ) ? CMD_READ : CMD_ZERO;
          res_nxt.send_channel = cmd.channel;
        end
      end
      OP_CLEAR: begin
        if (cmd.ch_ok) begin
          trk_we   = 1'b1;
          trk_ch   = cmd.channel;
          trk_raw  = '0;
          trk_turn = '0;
        end
      end
      OP_REPLY: begin
        case (phase_r)
          PH_RD_CMD, PH_ZR_CMD: begin
            try_nxt              = '0;
            res_nxt.send_valid   = 1'b1;
            res_nxt.send_byte    = CMD_POLL;
            res_nxt.send_channel = act_ch_r;
          end
          PH_RD_POLL: begin
            if (cmd.rx_byte == CMD_READ) begin
              res_nxt.send_valid   = 1'b1;
              res_nxt.send_byte    = CMD_POLL;
              res_nxt.send_channel = act_ch_r;
            end else begin
              try_nxt = try_inc;
              if (rd_timeout) begin
                res_nxt.done_res  = 1'b1;
                res_nxt.done_kind = act_kind_r;
                res_nxt.status    = 1'b1;
              end else begin
                res_nxt.send_valid   = 1'b1;
                res_nxt.send_byte    = CMD_POLL;
                res_nxt.send_channel = act_ch_r;
              end
            end
          end
          PH_RD_MSB: begin
            nib_nxt              = cmd.rx_byte[NIB_W-1:0];
            res_nxt.send_valid   = 1'b1;
            res_nxt.send_byte    = CMD_POLL;
            res_nxt.send_channel = act_ch_r;
          end
          PH_RD_LSB: begin
            trk_we            = 1'b1;
            res_nxt.done_res  = 1'b1;
            res_nxt.raw_count = raw;
            res_nxt.position  = {turn_new, raw};
          end
          PH_ZR_POLL: begin
            if (cmd.rx_byte == ACK_ZERO) begin
              res_nxt.done_res  = 1'b1;
              res_nxt.done_kind = 1'b1;
            end else begin
              try_nxt = try_inc;
              if (zr_timeout) begin
                res_nxt.done_res  = 1'b1;
                res_nxt.done_kind = act_kind_r;
                res_nxt.status    = 1'b1;
              end else begin
                res_nxt.send_valid   = 1'b1;
                res_nxt.send_byte    = CMD_POLL;
                res_nxt.send_channel = act_ch_r;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      act_ch_r    <= '0;
      act_kind_r  <= 1'b0;
      try_r       <= '0;
      nib_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        last_raw_r[i] <= '0;
        turn_r[i]     <= '0;
      end
    end else begin
      if (take) begin
        phase_r     <= phase_nxt;
        act_ch_r    <= act_ch_nxt;
        act_kind_r  <= act_kind_nxt;
        try_r       <= try_nxt;
        nib_r       <= nib_nxt;
        out_valid_r <= 1'b1;
        if (trk_we) begin
          last_raw_r[trk_ch[ENC_IDX_W-1:0]] <= trk_raw;
          turn_r[trk_ch[ENC_IDX_W-1:0]]     <= trk_turn;
        end
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_lim_r <= READ_LIMIT_RST;
      zr_lim_r <= ZERO_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_READ_LIMIT: rd_lim_r <= cfg_wdata;
        REG_ZERO_LIMIT: zr_lim_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_item.valid        = out_valid_r;
  assign out_item.send_valid   = out_res_r.send_valid;
  assign out_item.send_byte    = out_res_r.send_byte;
  assign out_item.send_channel = out_res_r.send_channel;
  assign out_item.done_res     = out_res_r.done_res;
  assign out_item.done_kind    = out_res_r.done_kind;
  assign out_item.status       = out_res_r.status;
  assign out_item.raw_count    = out_res_r.raw_count;
  assign out_item.position     = out_res_r.position;

endmodule

>>> rtl/spi_absolute_encoder_reader.sv
// SPI absolute encoder reader, top level: queue front end and sequencer back end.
// Result path: an accepted item is written into a queue entry, then into the result register;
// the back end stalls while the result register holds an item that out_item has not taken.
// Throughput: 1 item per cycle, unless the result register is held back by out_item.ready.
// Reset: synchronous, active-low rst_n; clears queue, sequencer and tracking, try limits to 80/120.
// Depends on sae_pkg, sae_if, sae_front and sae_back.
module spi_absolute_encoder_reader import sae_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  sae_in_if.sink                in_item,
  sae_out_if.source             out_item
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  sae_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  sae_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .out_item  (out_item)
  );

endmodule
